// ----- rtl/udsc_pkg.sv -----
// ----------------------------------------------------------------------------
// udsc_pkg
// Shared types and codes for the up/down step counter with phase output.
// ----------------------------------------------------------------------------
package udsc_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_TOTAL   = 2'd0,
    CFG_ZERO_BASED   = 2'd1,
    CFG_BOUND_MODE   = 2'd2,
    CFG_RESET_TARGET = 2'd3
  } udsc_cfg_idx_t;

  // bound_mode codes
  localparam logic [1:0] MODE_STOP      = 2'd0;
  localparam logic [1:0] MODE_UNBOUNDED = 2'd1;
  localparam logic [1:0] MODE_LOOP      = 2'd2;

  // reset_target codes
  localparam logic [1:0] TGT_LOW  = 2'd0;
  localparam logic [1:0] TGT_MID  = 2'd1;
  localparam logic [1:0] TGT_HIGH = 2'd2;

  // register reset values
  localparam logic [1:0] BOUND_MODE_RST   = MODE_LOOP;
  localparam logic [1:0] RESET_TARGET_RST = TGT_LOW;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP,
    ST_DOWN,
    ST_RESET,
    ST_MOD_INIT,
    ST_MOD,
    ST_SCALE_INIT,
    ST_SCALE,
    ST_DONE
  } udsc_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic step_up;
    logic step_down;
    logic apply_reset;
    logic mod_init;
    logic mod_iter;
    logic scale_init;
    logic scale_iter;
    logic result_load;
  } udsc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_mod;
    logic iter_last;
    logic out_free;
  } udsc_stat_t;

endpackage

// ----- rtl/udsc_ifs.sv -----
// ----------------------------------------------------------------------------
// udsc channel interfaces
// Event input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface udsc_in_if;
  logic valid;
  logic ready;
  logic up_event;
  logic down_event;
  logic reset_event;

  modport source (output valid, up_event, down_event, reset_event, input ready);
  modport sink   (input valid, up_event, down_event, reset_event, output ready);
endinterface

interface udsc_out_if #(
  parameter int COUNT_WIDTH = 32,
  parameter int PHASE_BITS  = 12
);
  logic                          valid;
  logic                          ready;
  logic signed [COUNT_WIDTH-1:0] count_value;
  logic                          end_gate;
  logic        [PHASE_BITS-1:0]  phase_code;

  modport source (output valid, count_value, end_gate, phase_code, input ready);
  modport sink   (input valid, count_value, end_gate, phase_code, output ready);
endinterface

interface udsc_cfg_if #(
  parameter int DATA_W = 16
);
  logic              valid;
  logic              ready;
  logic [1:0]        index;
  logic [DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/udsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// udsc_ctrl
// Sequencer: steps one tick through up, down, reset, modulo (unbounded mode only) and phase scaling.
// ----------------------------------------------------------------------------
module udsc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output udsc_pkg::udsc_cmd_t cmd,
  input  udsc_pkg::udsc_stat_t stat
);
  import udsc_pkg::*;

  udsc_state_t state;
  udsc_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_UP;
      end
      ST_UP:    state_next = ST_DOWN;
      ST_DOWN:  state_next = ST_RESET;
      ST_RESET: begin
        state_next = stat.need_mod ? ST_MOD_INIT : ST_SCALE_INIT;
      end
      ST_MOD_INIT: state_next = ST_MOD;
      ST_MOD: begin
        if (stat.iter_last) state_next = ST_SCALE_INIT;
      end
      ST_SCALE_INIT: state_next = ST_SCALE;
      ST_SCALE: begin
        if (stat.iter_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_UP:         cmd.step_up     = 1'b1;
      ST_DOWN:       cmd.step_down   = 1'b1;
      ST_RESET:      cmd.apply_reset = 1'b1;
      ST_MOD_INIT:   cmd.mod_init    = 1'b1;
      ST_MOD:        cmd.mod_iter    = 1'b1;
      ST_SCALE_INIT: cmd.scale_init  = 1'b1;
      ST_SCALE:      cmd.scale_iter  = 1'b1;
      ST_DONE:       cmd.result_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ----- rtl/udsc_datapath.sv -----
// ----------------------------------------------------------------------------
// udsc_datapath
// Config registers, count state, serial modulo and phase scaler, result reg.
// ----------------------------------------------------------------------------
module udsc_datapath #(
  parameter int COUNT_WIDTH = 32,
  parameter int STEPS_WIDTH = 16,
  parameter int PHASE_BITS  = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  udsc_pkg::udsc_cmd_t  cmd,
  output udsc_pkg::udsc_stat_t stat,
  input  logic                 up_event,
  input  logic                 down_event,
  input  logic                 reset_event,
  udsc_cfg_if.sink             cfg,
  udsc_out_if.source           result
);
  import udsc_pkg::*;

  localparam int CW    = COUNT_WIDTH;
  localparam int SW    = STEPS_WIDTH;
  localparam int PB    = PHASE_BITS;
  localparam int WW    = ((CW > SW + 1) ? CW : SW + 1) + 1;
  localparam int MAXN  = (CW > PB) ? CW : PB;
  localparam int IW    = $clog2(MAXN);

  localparam logic signed [CW-1:0] CNT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CNT_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [WW-1:0] CNT_MAX_W = {{(WW-CW){1'b0}}, CNT_MAX};
  localparam logic [PB-1:0]        FULL = {PB{1'b1}};

  // configuration
  logic [SW-1:0] step_total;
  logic          zero_based;
  logic [1:0]    bound_mode;
  logic [1:0]    reset_target;

  // tick state
  logic                 up_ev, down_ev, reset_ev;
  logic [SW-1:0]        steps;
  logic [SW-1:0]        div;
  logic signed [CW-1:0] lb;
  logic signed [CW-1:0] ub;
  logic signed [CW-1:0] count_reg;
  logic                 rising_dir;

  // modulo and scaler
  logic [CW-1:0]        mag;
  logic [SW:0]          rem;
  logic                 neg;
  logic signed [WW-1:0] p_val;
  logic [SW:0]          r;
  logic [PB-1:0]        q;
  logic                 clamp_lo, clamp_hi;
  logic [IW-1:0]        iter;

  // result register
  logic                 out_valid;
  logic signed [CW-1:0] out_count;
  logic                 out_gate;
  logic [PB-1:0]        out_code;

  // combinational
  logic [SW-1:0]        steps_c;
  logic signed [WW-1:0] steps_w;
  logic signed [WW-1:0] ub_raw;
  logic signed [CW-1:0] ub_c;
  logic [SW-1:0]        div_c;
  logic signed [CW-1:0] cnt_inc, cnt_dec, cnt_step;
  logic signed [CW:0]   mid_sum;
  logic [SW:0]          rem_sh;
  logic [SW-1:0]        p_mod;
  logic signed [WW-1:0] p_c;
  logic [SW:0]          r_sh;
  logic [PB-1:0]        q_sh;
  logic [PB-1:0]        code_c;
  logic signed [WW-1:0] count_w;
  logic                 gate_c;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_total   <= SW'(16);
      zero_based   <= 1'b0;
      bound_mode   <= BOUND_MODE_RST;
      reset_target <= RESET_TARGET_RST;
    end else if (cfg.valid) begin
      unique case (udsc_cfg_idx_t'(cfg.index))
        CFG_STEP_TOTAL:   step_total   <= cfg.data[SW-1:0];
        CFG_ZERO_BASED:   zero_based   <= cfg.data[0];
        CFG_BOUND_MODE:   bound_mode   <= cfg.data[1:0];
        CFG_RESET_TARGET: reset_target <= cfg.data[1:0];
        default: ;
      endcase
    end
  end

  // bounds from config, registered at capture
  always_comb begin
    steps_c = (step_total == '0) ? SW'(1) : step_total;
    steps_w = {{(WW-SW){1'b0}}, steps_c};
    ub_raw  = zero_based ? (steps_w - WW'(1)) : steps_w;
    ub_c    = (ub_raw > CNT_MAX_W) ? CNT_MAX : ub_raw[CW-1:0];
    if (zero_based) begin
      div_c = (steps_c > SW'(1)) ? (steps_c - SW'(1)) : SW'(1);
    end else begin
      div_c = steps_c;
    end
  end

  // one up or down step with bound handling
  always_comb begin
    cnt_inc  = (count_reg != CNT_MAX) ? (count_reg + CW'(1)) : count_reg;
    cnt_dec  = (count_reg != CNT_MIN) ? (count_reg - CW'(1)) : count_reg;
    cnt_step = count_reg;
    if (cmd.step_up) begin
      cnt_step = cnt_inc;
      if (cnt_inc > ub) begin
        if (bound_mode == MODE_STOP)      cnt_step = ub;
        else if (bound_mode == MODE_LOOP) cnt_step = lb;
      end
    end else begin
      cnt_step = cnt_dec;
      if (cnt_dec < lb) begin
        if (bound_mode == MODE_STOP)      cnt_step = lb;
        else if (bound_mode == MODE_LOOP) cnt_step = ub;
      end
    end
    mid_sum = {lb[CW-1], lb} + {ub[CW-1], ub};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg  <= CW'(1);
      rising_dir <= 1'b1;
    end else begin
      if (cmd.step_up && up_ev) begin
        count_reg  <= cnt_step;
        rising_dir <= 1'b1;
      end
      if (cmd.step_down && down_ev) begin
        count_reg  <= cnt_step;
        rising_dir <= 1'b0;
      end
      if (cmd.apply_reset && reset_ev) begin
        case (reset_target)
          TGT_LOW:  count_reg <= lb;
          TGT_MID:  count_reg <= mid_sum[CW:1];
          TGT_HIGH: count_reg <= ub;
          default:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      up_ev    <= up_event;
      down_ev  <= down_event;
      reset_ev <= reset_event;
      steps    <= steps_c;
      div      <= div_c;
      lb       <= zero_based ? CW'(0) : CW'(1);
      ub       <= ub_c;
    end
  end

  // magnitude modulo steps, one bit per cycle, then floored fix-up
  always_comb begin
    rem_sh = {rem[SW-1:0], mag[CW-1]};
    if (neg && (rem != '0)) begin
      p_mod = steps - rem[SW-1:0];
    end else begin
      p_mod = rem[SW-1:0];
    end
    count_w = {{(WW-CW){count_reg[CW-1]}}, count_reg};
    p_c     = stat.need_mod ? {{(WW-SW){1'b0}}, p_mod} : count_w;
    r_sh    = {r[SW-1:0], 1'b0};
    q_sh    = {q[PB-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_init) begin
      mag  <= count_reg[CW-1] ? (CW'(0) - count_reg) : count_reg;
      neg  <= count_reg[CW-1];
      rem  <= '0;
      iter <= IW'(CW - 1);
    end
    if (cmd.mod_iter) begin
      mag  <= {mag[CW-2:0], 1'b0};
      rem  <= (rem_sh >= {1'b0, steps}) ? (rem_sh - {1'b0, steps}) : rem_sh;
      iter <= iter - IW'(1);
    end
    if (cmd.scale_init) begin
      p_val    <= p_c;
      r        <= {1'b0, p_c[SW-1:0]};
      q        <= '0;
      clamp_lo <= (p_c <= WW'(0));
      clamp_hi <= (p_c >= {{(WW-SW){1'b0}}, div});
      iter     <= IW'(PB - 1);
    end
    if (cmd.scale_iter) begin
      if (r_sh >= {1'b0, div}) begin
        r <= r_sh - {1'b0, div};
        q <= q_sh | PB'(1);
      end else begin
        r <= r_sh;
        q <= q_sh;
      end
      iter <= iter - IW'(1);
    end
  end

  // final code and end gate
  always_comb begin
    if (clamp_lo) begin
      code_c = '0;
    end else if (clamp_hi) begin
      code_c = FULL;
    end else if (r < {1'b0, p_val[SW-1:0]}) begin
      code_c = q - PB'(1);
    end else begin
      code_c = q;
    end
    if (bound_mode != MODE_STOP) begin
      gate_c = zero_based ? (count_reg == '0) : (count_w == {{(WW-SW){1'b0}}, steps});
    end else begin
      gate_c = (!rising_dir && (count_reg == lb)) || (rising_dir && (count_reg == ub));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_count <= count_reg;
      out_gate  <= gate_c;
      out_code  <= code_c;
    end
  end

  assign result.valid       = out_valid;
  assign result.count_value = out_count;
  assign result.end_gate    = out_gate;
  assign result.phase_code  = out_code;

  assign stat.need_mod  = (bound_mode == MODE_UNBOUNDED);
  assign stat.iter_last = (iter == '0);
  assign stat.out_free  = !out_valid || result.ready;

endmodule

// ----- rtl/up_down_step_counter_with_phase.sv -----
// ----------------------------------------------------------------------------
// up_down_step_counter_with_phase
// Step counter with clamp, unbounded or wrap bounds and a stepped phase code.
//
//   channel  role   payload
//   events   sink   up_event, down_event, reset_event
//   result   source count_value, end_gate, phase_code
//   cfg      sink   index, data (always ready)
//
// an item runs the up, down and reset steps, then the one-bit-per-cycle modulo
// (unbounded mode only) and phase scaler, and its result is loaded into the output reg.
// one item at a time; the next is taken once the result is in the output reg.
// a stalled result holds the sequencer in its last step.
// reset: count 1, rising, steps 16, one-based, loop mode, reset to low bound.
// ----------------------------------------------------------------------------
module up_down_step_counter_with_phase #(
  parameter int COUNT_WIDTH = 32,
  parameter int STEPS_WIDTH = 16,
  parameter int PHASE_BITS  = 12
) (
  input  logic       clk,
  input  logic       rst,
  udsc_in_if.sink    events,
  udsc_out_if.source result,
  udsc_cfg_if.sink   cfg
);
  import udsc_pkg::*;

  udsc_cmd_t  cmd;
  udsc_stat_t stat;

  udsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (events.valid),
    .in_ready (events.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  udsc_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .STEPS_WIDTH (STEPS_WIDTH),
    .PHASE_BITS  (PHASE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .up_event    (events.up_event),
    .down_event  (events.down_event),
    .reset_event (events.reset_event),
    .cfg         (cfg),
    .result      (result)
  );

`ifndef SYNTH
  // sequencer drives at most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command active");

  // a transfer on events starts a tick, so no second transfer follows at once
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    (events.valid && events.ready) |=> !events.ready)
    else $error("events taken while a tick is in progress");

  // loading a result always presents it on the next cycle
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |=> result.valid)
    else $error("loaded result not presented");
`endif

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the up/down step counter with phase output. A
// driver feeds event ticks from a queue, a scoreboard model predicts count,
// end gate and phase code per transfer, and a monitor compares each result.
// Configuration is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import udsc_pkg::*;

  localparam int COUNT_WIDTH = 32;
  localparam int STEPS_WIDTH = 16;
  localparam int PHASE_BITS  = 12;

  localparam longint CNT_MAX    = (longint'(1) << (COUNT_WIDTH - 1)) - 1;
  localparam longint CNT_MIN    = -CNT_MAX - 1;
  localparam longint PHASE_FULL = (longint'(1) << PHASE_BITS) - 1;

  // codes the package leaves unnamed
  localparam logic [1:0] MODE_FREE = 2'd3;
  localparam logic [1:0] TGT_KEEP  = 2'd3;

  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 96;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 80;

  typedef struct packed {
    logic up_event;
    logic down_event;
    logic reset_event;
  } tick_t;

  typedef struct {
    logic signed [COUNT_WIDTH-1:0] count_value;
    logic                          end_gate;
    logic        [PHASE_BITS-1:0]  phase_code;
  } outcome_t;

  bit clk = 1'b0;
  bit rst = 1'b1;

  udsc_in_if                                                      ev_if  ();
  udsc_out_if #(.COUNT_WIDTH(COUNT_WIDTH), .PHASE_BITS(PHASE_BITS)) res_if ();
  udsc_cfg_if #(.DATA_W(STEPS_WIDTH))                             cfg_if ();

  up_down_step_counter_with_phase #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .STEPS_WIDTH(STEPS_WIDTH),
    .PHASE_BITS (PHASE_BITS)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .events(ev_if),
    .result(res_if),
    .cfg   (cfg_if)
  );

  always #2 clk = ~clk;

  // model state and register copy
  logic [STEPS_WIDTH-1:0] cfg_steps  = 16;
  logic                   cfg_zero   = 1'b0;
  logic [1:0]             cfg_mode   = MODE_LOOP;
  logic [1:0]             cfg_target = TGT_LOW;
  longint                 cur_count  = 1;
  bit                     cur_rising = 1'b1;

  tick_t    tick_q[$];
  outcome_t outcome_q[$];
  int       ticks_queued = 0;
  int       outcomes_seen = 0;
  int       errors = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  bit       hold_go = 1'b0;
  bit       hold_active = 1'b0;
  bit       run_up = 1'b1;

  function automatic longint clamp_count(longint v);
    if (v > CNT_MAX) return CNT_MAX;
    if (v < CNT_MIN) return CNT_MIN;
    return v;
  endfunction

  // applies one tick to the model and returns what the block should emit
  function automatic outcome_t advance_counter(tick_t t);
    longint   steps, lo, hi, p, d;
    outcome_t o;
    steps = (cfg_steps == 0) ? 1 : longint'(cfg_steps);
    lo = clamp_count(cfg_zero ? 0 : 1);
    hi = clamp_count(cfg_zero ? steps - 1 : steps);
    if (t.up_event) begin
      if (cur_count < CNT_MAX) cur_count = cur_count + 1;
      if (cur_count > hi) begin
        if (cfg_mode == MODE_STOP) cur_count = hi;
        else if (cfg_mode == MODE_LOOP) cur_count = lo;
      end
      cur_rising = 1'b1;
    end
    if (t.down_event) begin
      if (cur_count > CNT_MIN) cur_count = cur_count - 1;
      if (cur_count < lo) begin
        if (cfg_mode == MODE_STOP) cur_count = lo;
        else if (cfg_mode == MODE_LOOP) cur_count = hi;
      end
      cur_rising = 1'b0;
    end
    if (t.reset_event) begin
      case (cfg_target)
        TGT_LOW:  cur_count = lo;
        TGT_MID:  cur_count = (lo + hi) / 2;
        TGT_HIGH: cur_count = hi;
        default:  ;
      endcase
    end
    p = cur_count;
    // floored modulo folds the free-running count back into one range
    if (cfg_mode == MODE_UNBOUNDED) p = ((p % steps) + steps) % steps;
    if (cfg_zero) d = (steps - 1 < 1) ? 1 : steps - 1;
    else d = steps;
    if (p <= 0) o.phase_code = '0;
    else if (p >= d) o.phase_code = PHASE_FULL[PHASE_BITS-1:0];
    else o.phase_code = PHASE_BITS'((p * PHASE_FULL) / d);
    if (cfg_mode != MODE_STOP) begin
      o.end_gate = cfg_zero ? (cur_count == 0) : (cur_count == steps);
    end else begin
      o.end_gate = (!cur_rising && cur_count == lo) || (cur_rising && cur_count == hi);
    end
    o.count_value = cur_count[COUNT_WIDTH-1:0];
    return o;
  endfunction

  // mostly runs in one direction so bounds get crossed, with resets and noise
  function automatic tick_t next_tick();
    tick_t t;
    int    r;
    r = $urandom_range(99);
    if ($urandom_range(11) == 0) run_up = ~run_up;
    if (r < 70) t = '{run_up, !run_up, 1'b0};
    else if (r < 78) t = '{1'b1, 1'b1, 1'b0};
    else if (r < 84) t = '{1'b0, 1'b0, 1'b1};
    else t = tick_t'(3'($urandom_range(7)));
    return t;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic add_tick(logic u, logic d, logic r);
    tick_q.push_back('{u, d, r});
    ticks_queued++;
  endtask

  task automatic write_reg(udsc_cfg_idx_t idx, logic [STEPS_WIDTH-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_STEP_TOTAL:   cfg_steps  = val;
      CFG_ZERO_BASED:   cfg_zero   = val[0];
      CFG_BOUND_MODE:   cfg_mode   = val[1:0];
      CFG_RESET_TARGET: cfg_target = val[1:0];
    endcase
  endtask

  // unused upper data bits carry noise, the block keeps only the low bits
  task automatic set_config(logic [STEPS_WIDTH-1:0] st, logic zb, logic [1:0] md,
                            logic [1:0] tg);
    write_reg(CFG_STEP_TOTAL, st);
    write_reg(CFG_ZERO_BASED, {(STEPS_WIDTH-1)'($urandom), zb});
    write_reg(CFG_BOUND_MODE, {(STEPS_WIDTH-2)'($urandom), md});
    write_reg(CFG_RESET_TARGET, {(STEPS_WIDTH-2)'($urandom), tg});
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk); while (outcomes_seen < ticks_queued);
  endtask

  // driver
  always @(posedge clk) begin
    tick_t nxt;
    tick_t got;
    if (rst) begin
      ev_if.valid       <= 1'b0;
      ev_if.up_event    <= 1'b0;
      ev_if.down_event  <= 1'b0;
      ev_if.reset_event <= 1'b0;
    end else begin
      if (ev_if.valid && ev_if.ready) begin
        got = '{ev_if.up_event, ev_if.down_event, ev_if.reset_event};
        outcome_q.push_back(advance_counter(got));
      end
      if (!ev_if.valid || ev_if.ready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = tick_q.pop_front();
          ev_if.valid       <= 1'b1;
          ev_if.up_event    <= nxt.up_event;
          ev_if.down_event  <= nxt.down_event;
          ev_if.reset_event <= nxt.reset_event;
        end else begin
          ev_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        outcomes_seen++;
        if (outcome_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending, count %0d",
                                    res_if.count_value));
        end else begin
          want = outcome_q.pop_front();
          if (res_if.count_value !== want.count_value)
            report_mismatch($sformatf("count_value %0d, want %0d",
                                      res_if.count_value, want.count_value));
          if (res_if.end_gate !== want.end_gate)
            report_mismatch($sformatf("end_gate %0b, want %0b",
                                      res_if.end_gate, want.end_gate));
          if (res_if.phase_code !== want.phase_code)
            report_mismatch($sformatf("phase_code %0d, want %0d",
                                      res_if.phase_code, want.phase_code));
        end
      end
      res_if.ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [STEPS_WIDTH-1:0] st;
    logic                   zb;
    logic [1:0]             md;
    logic [1:0]             tg;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_STEP_TOTAL;
    cfg_if.data       = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset config: every event mix but reset alone, wrap below low bound and above high bound
    add_tick(0, 0, 0);
    add_tick(1, 0, 0);
    add_tick(1, 1, 0);
    add_tick(1, 1, 1);
    add_tick(0, 1, 1);
    add_tick(0, 1, 0);
    add_tick(1, 0, 0);
    add_tick(1, 0, 1);
    drain();

    // two steps from zero, clamping, midpoint reset
    set_config(16'd2, 1'b1, MODE_STOP, TGT_MID);
    add_tick(1, 0, 0);
    add_tick(1, 0, 0);
    add_tick(0, 1, 0);
    add_tick(0, 1, 0);
    add_tick(0, 1, 0);
    add_tick(0, 0, 1);
    add_tick(1, 1, 1);
    drain();

    // zero step total, free count below the range, negative count through the modulo
    set_config(16'd0, 1'b0, MODE_UNBOUNDED, TGT_HIGH);
    add_tick(0, 1, 0);
    add_tick(0, 1, 0);
    add_tick(0, 1, 0);
    add_tick(1, 0, 0);
    add_tick(0, 0, 1);
    drain();

    // bound mode three and reset target three at the widest range
    set_config(16'hFFFF, 1'b1, MODE_FREE, TGT_KEEP);
    add_tick(0, 0, 1);
    add_tick(0, 1, 0);
    add_tick(0, 1, 0);
    add_tick(1, 0, 1);
    add_tick(1, 0, 0);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(9))
        0:       st = 16'd0;
        1:       st = 16'd1;
        2:       st = 16'hFFFF;
        3:       st = 16'($urandom_range(16'hFFFF));
        4:       st = 16'd2;
        default: st = 16'($urandom_range(24, 3));
      endcase
      zb = 1'($urandom_range(1));
      md = 2'($urandom_range(3));
      tg = 2'($urandom_range(3));
      if (ph == 1) begin
        st = 16'hFFFF;
        zb = 1'b0;
        md = MODE_LOOP;
        tg = TGT_HIGH;
      end else if (ph == 2) begin
        st = 16'd1;
        zb = 1'b1;
        md = MODE_STOP;
        tg = TGT_LOW;
      end
      set_config(st, zb, md, tg);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      if (ph == 4) hold_go = 1'b1;
      repeat (PHASE_ITEMS) begin
        tick_q.push_back(next_tick());
        ticks_queued++;
      end
      drain();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (outcome_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", outcome_q.size()));
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/udsc_pkg.sv
rtl/udsc_ifs.sv
rtl/udsc_ctrl.sv
rtl/udsc_datapath.sv
rtl/up_down_step_counter_with_phase.sv
test/tb.sv
